// ===== design/assert_macros.svh =====
// Assertion macros shared by the file type sniffer RTL.
// No dependencies; assertions drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define FTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define FTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define FTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/fts_pkg.sv =====
// Package for the file type sniffer: kind codes, register map, header type
// and the byte/signature helper functions. No dependencies.
`default_nettype none
package fts_pkg;

	// Result kind codes
	localparam logic [3:0] KIND_EMPTY   = 4'd0;
	localparam logic [3:0] KIND_ELF     = 4'd1;
	localparam logic [3:0] KIND_SCRIPT  = 4'd2;
	localparam logic [3:0] KIND_PNG     = 4'd3;
	localparam logic [3:0] KIND_JPEG    = 4'd4;
	localparam logic [3:0] KIND_GIF     = 4'd5;
	localparam logic [3:0] KIND_PDF     = 4'd6;
	localparam logic [3:0] KIND_ZIP     = 4'd7;
	localparam logic [3:0] KIND_TEXT    = 4'd8;
	localparam logic [3:0] KIND_UNKNOWN = 4'd9;

	// Register map (register index = paddr[2])
	localparam logic REG_TEXT_PERCENT = 1'b0;
	localparam logic [6:0] TEXT_PERCENT_RESET = 7'd90;

	// First eight bytes of the file, byte 0 at index 0
	typedef logic [7:0][7:0] hdr_t;

	// Tab, line feed, carriage return and 0x20..0x7E count as printable
	function automatic logic is_printable(input logic [7:0] c);
		return (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
			((c >= 8'h20) && (c <= 8'h7E));
	endfunction

	// Signature match in priority order. have[k-1] is set when at least k
	// bytes were sampled. KIND_TEXT here means no signature matched and the
	// printable ratio still has to decide.
	function automatic logic [3:0] head_kind(input hdr_t h, input logic [7:0] have);
		logic [3:0] k;
		k = KIND_TEXT;
		priority if (!have[0]) begin
			k = KIND_EMPTY;
		end else if (have[3] && h[0] == 8'h7F && h[1] == 8'h45 && h[2] == 8'h4C &&
				h[3] == 8'h46) begin
			k = KIND_ELF;
		end else if (have[1] && h[0] == 8'h23 && h[1] == 8'h21) begin
			k = KIND_SCRIPT;
		end else if (have[7] && h[0] == 8'h89 && h[1] == 8'h50 && h[2] == 8'h4E &&
				h[3] == 8'h47 && h[4] == 8'h0D && h[5] == 8'h0A && h[6] == 8'h1A &&
				h[7] == 8'h0A) begin
			k = KIND_PNG;
		end else if (have[2] && h[0] == 8'hFF && h[1] == 8'hD8 && h[2] == 8'hFF) begin
			k = KIND_JPEG;
		end else if (have[5] && h[0] == 8'h47 && h[1] == 8'h49 && h[2] == 8'h46 &&
				h[3] == 8'h38 && (h[4] == 8'h37 || h[4] == 8'h39) && h[5] == 8'h61) begin
			k = KIND_GIF;
		end else if (have[3] && h[0] == 8'h25 && h[1] == 8'h50 && h[2] == 8'h44 &&
				h[3] == 8'h46) begin
			k = KIND_PDF;
		end else if (have[3] && h[0] == 8'h50 && h[1] == 8'h4B && h[2] == 8'h03 &&
				h[3] == 8'h04) begin
			k = KIND_ZIP;
		end else begin
			k = KIND_TEXT;
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== design/fts_in_if.sv =====
// Input channel of the file type sniffer: one file byte per beat.
// No dependencies.
`default_nettype none
interface fts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       no_data;

	modport source(output valid, data_byte, last_byte, no_data, input ready);
	modport sink(input valid, data_byte, last_byte, no_data, output ready);
endinterface
`default_nettype wire

// ===== design/fts_out_if.sv =====
// Output channel of the file type sniffer: one verdict per beat.
// No dependencies.
`default_nettype none
interface fts_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] file_kind;
	logic [9:0] sampled_count;

	modport source(output valid, file_kind, sampled_count, input ready);
	modport sink(input valid, file_kind, sampled_count, output ready);
endinterface
`default_nettype wire

// ===== design/fts_verdict.sv =====
// Verdict stage: holds one finished file tally, resolves text vs. binary by
// the printable ratio and drives the output register. Uses fts_pkg, fts_out_if.
`default_nettype none
`include "assert_macros.svh"
module fts_verdict
	import fts_pkg::*;
#(
	parameter int CW = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [6:0]    text_percent,
	input  wire logic          tally_valid,
	output      logic          tally_ready,
	input  wire logic [3:0]    tally_kind,
	input  wire logic [CW-1:0] tally_count,
	input  wire logic [CW-1:0] tally_printable,
	fts_out_if.source          out
);

	localparam int PW = CW + 7;

	logic          v_s2;
	logic [3:0]    kind_s2;
	logic [CW-1:0] cnt_s2;
	logic [CW-1:0] prn_s2;

	logic          out_v_q;
	logic [3:0]    kind_q;
	logic [9:0]    cnt_q;

	logic          load_out;
	logic [PW-1:0] prn_x100;
	logic [PW-1:0] pct_x_cnt;
	logic          is_text;
	logic [3:0]    kind_fin;
	logic [CW+9:0] cnt_ext;

	// Handshake: output register frees s2, s2 frees the tally side
	assign load_out    = v_s2 && (!out_v_q || out.ready);
	assign tally_ready = !v_s2 || load_out;

	// Stage 2 tally register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (tally_valid && tally_ready) begin
			v_s2 <= 1'b1;
		end else if (load_out) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tally_valid && tally_ready) begin
			kind_s2 <= tally_kind;
			cnt_s2  <= tally_count;
			prn_s2  <= tally_printable;
		end
	end

	// Text when printable * 100 > percent * count
	assign prn_x100  = {7'd0, prn_s2} * PW'(100);
	assign pct_x_cnt = {{CW{1'b0}}, text_percent} * {7'd0, cnt_s2};
	assign is_text   = prn_x100 > pct_x_cnt;

	always_comb begin
		kind_fin = kind_s2;
		if (kind_s2 == KIND_TEXT) begin
			kind_fin = is_text ? KIND_TEXT : KIND_UNKNOWN;
		end
	end

	// Count goes out as its low ten bits
	assign cnt_ext = {10'd0, cnt_s2};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q <= kind_fin;
			cnt_q  <= cnt_ext[9:0];
		end
	end

	assign out.valid         = out_v_q;
	assign out.file_kind     = kind_q;
	assign out.sampled_count = cnt_q;

	// A tally taken in is held in s2 the next cycle
	`FTS_ASSERT_NEXT(a_tally_taken, clk, arst_n, tally_valid && tally_ready, v_s2, "tally beat lost")
	// A blocked tally keeps its contents
	`FTS_ASSERT_NEXT(a_s2_hold, clk, arst_n, v_s2 && !load_out, v_s2 && $stable(kind_s2) && $stable(cnt_s2) && $stable(prn_s2), "stalled tally changed")
	// An empty verdict never carries a byte count
	`FTS_ASSERT_IMPLY(a_empty_zero, clk, arst_n, out_v_q && kind_q == KIND_EMPTY, cnt_q == 10'd0, "empty file with nonzero count")

endmodule
`default_nettype wire

// ===== design/file_type_sniffer.sv =====
// File type sniffer: takes a file one byte per beat and returns one verdict beat
// (file_kind, sampled_count) after the beat marked last_byte. Only the first
// SAMPLE_LIMIT bytes are looked at; the first eight are matched against ELF,
// shebang, PNG, JPEG, GIF, PDF and ZIP signatures in that order, otherwise the
// printable share against text_percent (APB register at byte address 0, reset
// 90) picks text or unknown. A last beat with no byte and nothing sampled gives
// the empty kind. One byte is taken every cycle unless a last beat waits for the
// verdict stage; the count update is the only loop. A verdict passes through s2
// to the output register; the next file may start once the last beat enters s2.
// Depends on fts_pkg, fts_in_if, fts_out_if, fts_verdict.
`default_nettype none
module file_type_sniffer
	import fts_pkg::*;
#(
	parameter int SAMPLE_LIMIT = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	fts_in_if.sink           in,
	fts_out_if.source        out
);

	localparam int CW = $clog2(SAMPLE_LIMIT + 1);

	// Configuration register
	logic [6:0] pct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= TEXT_PERCENT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_PERCENT) begin
			pct_q <= pwdata[6:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TEXT_PERCENT) ? {25'd0, pct_q} : 32'd0;

	// Stage 1 input register
	logic       v_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       nd_s1;
	logic       adv_s1;
	logic       fire_s1;
	logic       tally_ready;

	assign adv_s1   = !last_s1 || tally_ready;
	assign fire_s1  = v_s1 && adv_s1;
	assign in.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in.valid && in.ready) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			data_s1 <= in.data_byte;
			last_s1 <= in.last_byte;
			nd_s1   <= in.no_data;
		end
	end

	// Per-file tally
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] prn_q;
	hdr_t          hdr_q;
	logic          take;
	logic          hdr_wr;
	logic [CW-1:0] cnt_nx;
	logic [CW-1:0] prn_nx;
	hdr_t          hdr_nx;
	logic [7:0]    have;

	assign take   = !nd_s1 && (cnt_q < CW'(SAMPLE_LIMIT));
	assign hdr_wr = take && (cnt_q < CW'(8));
	assign cnt_nx = cnt_q + CW'(take);
	assign prn_nx = prn_q + CW'(take && is_printable(data_s1));

	always_comb begin
		hdr_nx = hdr_q;
		if (hdr_wr) begin
			hdr_nx[cnt_q[2:0]] = data_s1;
		end
	end

	// Length qualifiers for the signature checks
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			have[k] = cnt_nx >= CW'(k + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			prn_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				cnt_q <= '0;
				prn_q <= '0;
			end else begin
				cnt_q <= cnt_nx;
				prn_q <= prn_nx;
			end
		end
	end

	// Header bytes are only read below the count, so they need no clear
	always_ff @(posedge clk) begin
		if (fire_s1 && hdr_wr) begin
			hdr_q[cnt_q[2:0]] <= data_s1;
		end
	end

	// Verdict stage
	fts_verdict #(
		.CW(CW)
	) u_verdict (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_percent    (pct_q),
		.tally_valid     (v_s1 && last_s1),
		.tally_ready     (tally_ready),
		.tally_kind      (head_kind(hdr_nx, have)),
		.tally_count     (cnt_nx),
		.tally_printable (prn_nx),
		.out             (out)
	);

endmodule
`default_nettype wire

// ===== sim/tb_file_type_sniffer.sv =====
// Testbench for file_type_sniffer: streams files one byte per beat, predicts each
// verdict in a behavioral sniffer and checks it field by field at the output.
// Depends on fts_pkg, fts_in_if, fts_out_if and the file_type_sniffer RTL.
`timescale 1ns / 100ps
module tb_file_type_sniffer;
	import fts_pkg::*;

	localparam int SAMPLE_LIMIT = 512;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int TIMEOUT_NS   = 3_000_000;

	// Signatures, byte 0 in the top octet
	localparam logic [63:0] SIG_ELF    = 64'h7F454C46_00000000;
	localparam logic [63:0] SIG_SCRIPT = 64'h23210000_00000000;
	localparam logic [63:0] SIG_PNG    = 64'h89504E47_0D0A1A0A;
	localparam logic [63:0] SIG_JPEG   = 64'hFFD8FF00_00000000;
	localparam logic [63:0] SIG_GIF87  = {"GIF87a", 16'h0000};
	localparam logic [63:0] SIG_GIF89  = {"GIF89a", 16'h0000};
	localparam logic [63:0] SIG_PDF    = {"%PDF", 32'h0000_0000};
	localparam logic [63:0] SIG_ZIP    = 64'h504B0304_00000000;

	typedef struct packed {
		logic [3:0] kind;
		logic [9:0] count;
	} verdict_t;

	// One input beat; fixed marks a row whose verdict is typed in by hand
	typedef struct packed {
		logic [7:0] octet;
		logic       last;
		logic       nodata;
		logic       fixed;
		verdict_t   fixed_v;
	} file_beat_t;

	localparam verdict_t NO_VERDICT = '{KIND_EMPTY, 10'd0};

	// Directed files, run with the reset share of 90 percent
	localparam file_beat_t DIRECTED[24] = '{
		'{8'h00, 1'b1, 1'b1, 1'b1, '{KIND_EMPTY, 10'd0}},   // empty file
		'{8'hA5, 1'b0, 1'b1, 1'b0, NO_VERDICT},             // only byteless beats
		'{8'h00, 1'b1, 1'b1, 1'b1, '{KIND_EMPTY, 10'd0}},
		'{8'h23, 1'b0, 1'b0, 1'b0, NO_VERDICT},             // shebang, two bytes
		'{8'h21, 1'b1, 1'b0, 1'b0, NO_VERDICT},
		'{8'h7F, 1'b0, 1'b0, 1'b0, NO_VERDICT},             // ELF, closed by byteless last
		'{8'h45, 1'b0, 1'b0, 1'b0, NO_VERDICT},
		'{8'h4C, 1'b0, 1'b0, 1'b0, NO_VERDICT},
		'{8'h46, 1'b0, 1'b0, 1'b0, NO_VERDICT},
		'{8'hFF, 1'b1, 1'b1, 1'b0, NO_VERDICT},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_VERDICT},             // JPEG
		'{8'hD8, 1'b0, 1'b0, 1'b0, NO_VERDICT},
		'{8'hFF, 1'b1, 1'b0, 1'b0, NO_VERDICT},
		'{8'h25, 1'b0, 1'b0, 1'b0, NO_VERDICT},             // PDF cut short
		'{8'h50, 1'b0, 1'b0, 1'b0, NO_VERDICT},
		'{8'h44, 1'b1, 1'b0, 1'b0, NO_VERDICT},
		'{8'h00, 1'b1, 1'b0, 1'b1, '{KIND_UNKNOWN, 10'd1}}, // byte extremes
		'{8'h7E, 1'b1, 1'b0, 1'b1, '{KIND_TEXT, 10'd1}},
		'{8'hFF, 1'b1, 1'b0, 1'b1, '{KIND_UNKNOWN, 10'd1}},
		'{8'h20, 1'b1, 1'b0, 1'b1, '{KIND_TEXT, 10'd1}},
		'{8'h7F, 1'b1, 1'b0, 1'b1, '{KIND_UNKNOWN, 10'd1}},
		'{8'h09, 1'b0, 1'b0, 1'b0, NO_VERDICT},             // whitespace controls
		'{8'h0D, 1'b0, 1'b0, 1'b0, NO_VERDICT},
		'{8'h0A, 1'b1, 1'b0, 1'b0, NO_VERDICT}
	};

	localparam logic [6:0] SHARES[6] = '{7'd0, 7'd100, 7'd127, 7'd90, 7'd1, 7'd99};
	localparam int IDLE_SRC[4] = '{0, 57, 0, 38};
	localparam int IDLE_SNK[4] = '{0, 0, 57, 38};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fts_in_if  file_in();
	fts_out_if verdicts();

	file_type_sniffer #(.SAMPLE_LIMIT(SAMPLE_LIMIT)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in      (file_in),
		.out     (verdicts)
	);

	// Sniffer state mirrored by the testbench
	logic [63:0] head_bits;
	int unsigned seen_cnt;
	int unsigned print_cnt;
	logic [6:0]  share_pct;

	file_beat_t  beat_q[$];
	verdict_t    verdict_q[$];
	file_beat_t  cur_beat;
	verdict_t    mon_v;
	verdict_t    mon_want;
	int          src_idle;
	int          snk_stall;
	int          hold_left;
	int          errors;
	int          beats_taken;
	int          verdicts_checked;
	int          share_settings;
	logic [15:0] kinds_seen;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop if the run hangs
	initial begin
		#(TIMEOUT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic bit text_char(input logic [7:0] c);
		return c == 8'h09 || c == 8'h0A || c == 8'h0D || (c >= 8'h20 && c <= 8'h7E);
	endfunction

	// True when the sampled head starts with the first n octets of sig
	function automatic bit head_starts(input logic [63:0] sig, input int n);
		logic [63:0] mask;
		mask = ~64'h0 << (64 - 8 * n);
		return seen_cnt >= n && (head_bits & mask) == (sig & mask);
	endfunction

	function automatic logic [3:0] sniff_kind();
		if (seen_cnt == 0) return KIND_EMPTY;
		if (head_starts(SIG_ELF, 4)) return KIND_ELF;
		if (head_starts(SIG_SCRIPT, 2)) return KIND_SCRIPT;
		if (head_starts(SIG_PNG, 8)) return KIND_PNG;
		if (head_starts(SIG_JPEG, 3)) return KIND_JPEG;
		if (head_starts(SIG_GIF87, 6) || head_starts(SIG_GIF89, 6)) return KIND_GIF;
		if (head_starts(SIG_PDF, 4)) return KIND_PDF;
		if (head_starts(SIG_ZIP, 4)) return KIND_ZIP;
		if (print_cnt * 100 > 32'(share_pct) * seen_cnt) return KIND_TEXT;
		return KIND_UNKNOWN;
	endfunction

	// Take one beat; returns 1 with the verdict when the beat closes a file
	function automatic bit sniff_step(input logic [7:0] d, input logic lst,
			input logic nd, output verdict_t v);
		v = NO_VERDICT;
		if (!nd && seen_cnt < SAMPLE_LIMIT) begin
			if (seen_cnt < 8)
				head_bits[63 - 8 * seen_cnt -: 8] = d;
			if (text_char(d))
				print_cnt++;
			seen_cnt++;
		end
		if (!lst)
			return 1'b0;
		v.kind = sniff_kind();
		v.count = 10'(seen_cnt);
		head_bits = '0;
		seen_cnt = 0;
		print_cnt = 0;
		return 1'b1;
	endfunction

	// Printable with probability ppct percent, otherwise a binary byte
	function automatic logic [7:0] pick_char(input int ppct);
		logic [7:0] c;
		if ($urandom_range(99) < ppct) begin
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(2))
					0: c = 8'h09;
					1: c = 8'h0A;
					default: c = 8'h0D;
				endcase
			end else begin
				c = 8'($urandom_range(8'h20, 8'h7E));
			end
		end else begin
			c = 8'($urandom_range(255));
			if (text_char(c))
				c = c | 8'h80;
		end
		return c;
	endfunction

	// Queue one file; force_len > 0 gives a plain file of that many bytes
	task automatic build_file(input int force_len);
		logic [7:0] body[$];
		logic [63:0] sig;
		int siglen;
		int cut;
		int ppct;
		int r;
		int idx;
		bit tail_nd;
		file_beat_t b;
		ppct = $urandom_range(100);
		r = $urandom_range(99);
		sig = SIG_ELF;
		siglen = 4;
		if (force_len > 0) begin
			repeat (force_len) body.push_back(pick_char(ppct));
		end else if (r < 55) begin
			case ($urandom_range(7))
				0: begin sig = SIG_ELF; siglen = 4; end
				1: begin sig = SIG_SCRIPT; siglen = 2; end
				2: begin sig = SIG_PNG; siglen = 8; end
				3: begin sig = SIG_JPEG; siglen = 3; end
				4: begin sig = SIG_GIF87; siglen = 6; end
				5: begin sig = SIG_GIF89; siglen = 6; end
				6: begin sig = SIG_PDF; siglen = 4; end
				default: begin sig = SIG_ZIP; siglen = 4; end
			endcase
			// mostly intact signatures, some cut short, some with a bad byte
			cut = siglen;
			r = $urandom_range(99);
			if (r < 15)
				cut = $urandom_range(1, siglen - 1);
			for (int i = 0; i < cut; i++)
				body.push_back(sig[63 - 8 * i -: 8]);
			if (r >= 15 && r < 35) begin
				idx = $urandom_range(cut - 1);
				body[idx] = body[idx] ^ 8'($urandom_range(1, 255));
			end
			repeat ($urandom_range(0, 12)) body.push_back(pick_char(ppct));
		end else if (r < 85) begin
			repeat ($urandom_range(1, 40)) body.push_back(pick_char(ppct));
		end else if (r < 95) begin
			repeat ($urandom_range(1, 16)) body.push_back(8'($urandom));
		end
		// byteless beats sprinkled in; sometimes a byteless beat closes the file
		tail_nd = body.size() == 0 || $urandom_range(99) < 20;
		b.fixed = 1'b0;
		b.fixed_v = NO_VERDICT;
		foreach (body[i]) begin
			if ($urandom_range(99) < 8) begin
				b.octet = 8'($urandom);
				b.last = 1'b0;
				b.nodata = 1'b1;
				beat_q.push_back(b);
			end
			b.octet = body[i];
			b.nodata = 1'b0;
			b.last = i == body.size() - 1 && !tail_nd;
			beat_q.push_back(b);
		end
		if (tail_nd) begin
			b.octet = 8'($urandom);
			b.nodata = 1'b1;
			b.last = 1'b1;
			beat_q.push_back(b);
		end
	endtask

	// Offer every queued beat, idling at random between beats
	task automatic push_beats();
		file_beat_t b;
		@(negedge clk);
		while (beat_q.size() > 0) begin
			b = beat_q.pop_front();
			while ($urandom_range(99) < src_idle) begin
				file_in.valid = 1'b0;
				file_in.data_byte = 8'($urandom);
				file_in.last_byte = 1'($urandom);
				file_in.no_data = 1'($urandom);
				@(negedge clk);
			end
			file_in.valid = 1'b1;
			file_in.data_byte = b.octet;
			file_in.last_byte = b.last;
			file_in.no_data = b.nodata;
			cur_beat = b;
			@(posedge clk);
			while (!file_in.ready) @(posedge clk);
			@(negedge clk);
		end
		file_in.valid = 1'b0;
	endtask

	task automatic apb_xfer(input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {REG_TEXT_PERCENT, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Write the share register with junk in the unused bits, then read it back
	task automatic set_share(input logic [6:0] pct);
		logic [31:0] rd;
		apb_xfer(1'b1, ($urandom & ~32'h7F) | 32'(pct), rd);
		share_pct = pct;
		share_settings++;
		apb_xfer(1'b0, 32'd0, rd);
		if (rd[6:0] !== pct) begin
			$error("text_percent: expected %0d, got %0d", pct, rd[6:0]);
			errors++;
		end
	endtask

	// Block is idle once every verdict is back and the pipe has drained
	task automatic wait_idle();
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Sink ready: long hold-off on request, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			verdicts.ready = 1'b0;
			hold_left--;
		end else begin
			verdicts.ready = $urandom_range(99) >= snk_stall;
		end
	end

	// Predict on accepted input beats, check accepted verdict beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (file_in.valid && file_in.ready) begin
				beats_taken++;
				if (sniff_step(file_in.data_byte, file_in.last_byte, file_in.no_data, mon_v))
					verdict_q.push_back(cur_beat.fixed ? cur_beat.fixed_v : mon_v);
			end
			if (verdicts.valid && verdicts.ready) begin
				if (verdict_q.size() == 0) begin
					$error("verdict beat with none pending: file_kind %0d sampled_count %0d",
						verdicts.file_kind, verdicts.sampled_count);
					errors++;
				end else begin
					mon_want = verdict_q.pop_front();
					if (verdicts.file_kind !== mon_want.kind) begin
						$error("file_kind: expected %0d, got %0d", mon_want.kind,
							verdicts.file_kind);
						errors++;
					end
					if (verdicts.sampled_count !== mon_want.count) begin
						$error("sampled_count: expected %0d, got %0d", mon_want.count,
							verdicts.sampled_count);
						errors++;
					end
					kinds_seen[mon_want.kind] = 1'b1;
					verdicts_checked++;
				end
			end
		end
	end

	initial begin
		logic [31:0] rd;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		file_in.valid = 1'b0;
		file_in.data_byte = '0;
		file_in.last_byte = 1'b0;
		file_in.no_data = 1'b0;
		verdicts.ready = 1'b0;
		cur_beat = '0;
		head_bits = '0;
		seen_cnt = 0;
		print_cnt = 0;
		share_pct = TEXT_PERCENT_RESET;
		src_idle = 0;
		snk_stall = 0;
		hold_left = 0;
		errors = 0;
		beats_taken = 0;
		verdicts_checked = 0;
		share_settings = 0;
		kinds_seen = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// share register comes up at its reset value
		apb_xfer(1'b0, 32'd0, rd);
		if (rd[6:0] !== TEXT_PERCENT_RESET) begin
			$error("text_percent: expected %0d, got %0d", TEXT_PERCENT_RESET, rd[6:0]);
			errors++;
		end

		foreach (DIRECTED[i]) beat_q.push_back(DIRECTED[i]);
		push_beats();
		wait_idle();

		// random files under each idle pattern and share setting
		for (int p = 0; p < 8; p++) begin
			src_idle = IDLE_SRC[p % 4];
			snk_stall = IDLE_SNK[p % 4];
			set_share(p < 6 ? SHARES[p] : 7'($urandom_range(127)));
			while (beat_q.size() < 12) build_file(0);
			push_beats();
			wait_idle();
		end

		// a file running through and past the sample limit
		src_idle = 0;
		snk_stall = 0;
		set_share(7'd90);
		build_file(SAMPLE_LIMIT + 8);
		push_beats();
		wait_idle();

		// sink holds off while tiny files keep coming, so the input backs up
		hold_left = HOLD_CYCLES;
		repeat (20) build_file($urandom_range(1, 3));
		push_beats();
		wait_idle();

		$display("Run: %0d file beats accepted, %0d verdicts checked, %0d share settings",
			beats_taken, verdicts_checked, share_settings);
		$display("Verdict kinds seen (bit per kind): %b", kinds_seen[9:0]);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/fts_pkg.sv
design/fts_in_if.sv
design/fts_out_if.sv
design/fts_verdict.sv
design/file_type_sniffer.sv
sim/tb_file_type_sniffer.sv
